FILE: rtl/nll_pkg.sv
// nll_pkg: shared types and constants for the nearest location lookup block.
// Used by nll_dist and nearest_location_lookup_core; no dependencies.
`timescale 1ns / 1ps
package nll_pkg;

	// command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_NONE = 2'd2;

	localparam int COORD_W = 16;
	localparam int LABEL_W = 16;
	localparam int COUNT_W = 7;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int DIST_W  = SQ_W + 1;
	localparam int BEST_W  = 20;
	localparam logic [BEST_W-1:0] RANGE_SQ = BEST_W'(1000000);

	typedef struct packed {
		logic [1:0]                cmd;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [LABEL_W-1:0]        label_in;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [LABEL_W-1:0] label_out;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	// one stored table entry
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [LABEL_W-1:0]        label;
	} entry_t;

	// distance pipeline output toward the compare logic
	typedef struct packed {
		logic               busy;
		logic               valid;
		logic [DIST_W-1:0]  dist_sq;
		logic [LABEL_W-1:0] label;
	} dist_res_t;

endpackage

FILE: rtl/nll_ram.sv
// nll_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module nll_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/nll_dist.sv
// nll_dist: three-stage squared distance pipeline (abs diff, square, sum).
// Depends on nll_pkg.
`timescale 1ns / 1ps
module nll_dist import nll_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	input  entry_t                    point,
	input  logic signed [COORD_W-1:0] qx,
	input  logic signed [COORD_W-1:0] qy,
	output dist_res_t                 res
);

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W:0]        dx_abs, dy_abs;

	logic               v_s1, v_s2, v_s3;
	logic [COORD_W-1:0] ax_s1, ay_s1;
	logic [LABEL_W-1:0] label_s1, label_s2, label_s3;
	logic [SQ_W-1:0]    sqx_s2, sqy_s2;
	logic [DIST_W-1:0]  dist_s3;

	always_comb begin
		dx = {point.x[COORD_W-1], point.x} - {qx[COORD_W-1], qx};
		dy = {point.y[COORD_W-1], point.y} - {qy[COORD_W-1], qy};
		dx_abs = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
		dy_abs = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1    <= dx_abs[COORD_W-1:0];
		ay_s1    <= dy_abs[COORD_W-1:0];
		label_s1 <= point.label;
		sqx_s2   <= ax_s1 * ax_s1;
		sqy_s2   <= ay_s1 * ay_s1;
		label_s2 <= label_s1;
		dist_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		label_s3 <= label_s2;
	end

	always_comb begin
		res.busy    = v_s1 | v_s2 | v_s3;
		res.valid   = v_s3;
		res.dist_sq = dist_s3;
		res.label   = label_s3;
	end

endmodule

FILE: rtl/nearest_location_lookup_core.sv
// nearest_location_lookup_core: top level, command sequencer, table RAM and scan.
// Depends on nll_pkg, nll_ram, nll_dist.
//
//  channel | dir | handshake        | payload
//  req     | in  | req_valid/stall  | req_t  (cmd, pos_x, pos_y, label_in)
//  rsp     | out | rsp_valid/stall  | rsp_t  (status, label_out, entry_count)
//
// Clear, append and unused codes load their result into the output register on accept.
// A query reads one table entry per cycle from the RAM port; each entry passes
// through nll_dist to the compare, then S_DONE loads the result into the output register.
// One item is in work at a time; req_stall is high while a query runs or the output is held.
// arst_n clears the entry count; table contents are left as they were.
`timescale 1ns / 1ps
module nearest_location_lookup_core import nll_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] issue_q;
	logic             rd_v_q;
	logic             found_q;
	logic [BEST_W-1:0]  best_q;
	logic [LABEL_W-1:0] best_label_q;
	logic signed [COORD_W-1:0] qx_q, qy_q;

	logic       rsp_valid_q;
	rsp_t       rsp_q;
	logic       rsp_load;
	rsp_t       rsp_next;
	logic       accept;
	logic       full;
	logic       issue;
	logic       scan_end;
	logic       ram_we;
	entry_t     wentry, rentry;
	dist_res_t  dres;
	logic [$bits(entry_t)-1:0] ram_rdata;

	assign full      = (cnt_q == CNT_FULL);
	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign issue     = (state_q == S_SCAN) && (issue_q != cnt_q);
	assign scan_end  = (state_q == S_SCAN) && (issue_q == cnt_q) && !rd_v_q && !dres.busy;
	assign ram_we    = accept && (req.cmd == CMD_APPEND) && !full;

	always_comb begin
		wentry.x     = req.pos_x;
		wentry.y     = req.pos_y;
		wentry.label = req.label_in;
	end

	nll_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(wentry),
		.raddr(issue_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign rentry = entry_t'(ram_rdata);

	nll_dist u_dist (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (rd_v_q),
		.point (rentry),
		.qx    (qx_q),
		.qy    (qy_q),
		.res   (dres)
	);

	// response select
	always_comb begin
		rsp_load = 1'b0;
		rsp_next.status      = STAT_OK;
		rsp_next.label_out   = '0;
		rsp_next.entry_count = COUNT_W'(cnt_q);
		if (accept) begin
			case (req.cmd)
				CMD_CLEAR: begin
					rsp_load = 1'b1;
					rsp_next.entry_count = '0;
				end
				CMD_APPEND: begin
					rsp_load = 1'b1;
					if (full) begin
						rsp_next.status = STAT_FULL;
					end else begin
						rsp_next.entry_count = COUNT_W'(cnt_q + 1'b1);
					end
				end
				CMD_QUERY: begin
					rsp_load = 1'b0;
				end
				default: begin
					rsp_load = 1'b1;
				end
			endcase
		end else if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_load = 1'b1;
			if (found_q) begin
				rsp_next.label_out = best_label_q;
			end else begin
				rsp_next.status = STAT_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			issue_q     <= '0;
			rd_v_q      <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_v_q <= issue;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_CLEAR: begin
								cnt_q <= '0;
							end
							CMD_APPEND: begin
								if (!full) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							CMD_QUERY: begin
								state_q <= S_SCAN;
								issue_q <= '0;
								found_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						issue_q <= issue_q + 1'b1;
					end
					if (dres.valid && dres.dist_sq < DIST_W'(best_q)) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// query point and running best; strict compare keeps the earlier entry on a tie
	always_ff @(posedge clk) begin
		if (accept && req.cmd == CMD_QUERY) begin
			qx_q   <= req.pos_x;
			qy_q   <= req.pos_y;
			best_q <= RANGE_SQ;
		end else if (state_q == S_SCAN && dres.valid && dres.dist_sq < DIST_W'(best_q)) begin
			best_q       <= dres.dist_sq[BEST_W-1:0];
			best_label_q <= dres.label;
		end
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for nearest_location_lookup_core.
// Runs directed, full-table and random command streams against a built-in table model.
// Depends on nll_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
	import nll_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 800;
	localparam int WAIT_MAX = 15;
	localparam longint RANGE_LIMIT = 1000000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// table model
	logic signed [COORD_W-1:0] map_x [DEPTH];
	logic signed [COORD_W-1:0] map_y [DEPTH];
	logic [LABEL_W-1:0] map_label [DEPTH];
	int map_count = 0;

	rsp_t expected_rsp [$];
	int fail_count = 0;
	int cycle_count = 0;
	int rx_wait = 0;
	bit no_idle = 1'b0;
	int n_sent = 0;
	int n_unused = 0;
	int n_checked = 0;
	int n_found = 0;
	int n_missed = 0;
	int n_dropped = 0;

	nearest_location_lookup_core #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, WAIT_MAX);
	endfunction

	function automatic logic signed [COORD_W-1:0] near_offset();
		return COORD_W'(int'($urandom_range(0, 2400)) - 1200);
	endfunction

	function automatic req_t make_req(input logic [1:0] cmd,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic [LABEL_W-1:0] label);
		req_t r;
		r.cmd = cmd;
		r.pos_x = x;
		r.pos_y = y;
		r.label_in = label;
		return r;
	endfunction

	// applies one command to the table model and returns the result it must produce
	function automatic rsp_t lookup_nearest(input req_t item);
		rsp_t r;
		longint best;
		longint dx;
		longint dy;
		longint d;
		r = '0;
		case (item.cmd)
			CMD_CLEAR: begin
				map_count = 0;
			end
			CMD_APPEND: begin
				if (map_count >= DEPTH) begin
					r.status = STAT_FULL;
					n_dropped++;
				end else begin
					map_x[map_count] = item.pos_x;
					map_y[map_count] = item.pos_y;
					map_label[map_count] = item.label_in;
					map_count++;
				end
			end
			CMD_QUERY: begin
				best = RANGE_LIMIT;
				r.status = STAT_NONE;
				// strict compare: on a tie the earlier entry stays
				for (int i = 0; i < map_count; i++) begin
					dx = longint'(map_x[i]) - longint'($signed(item.pos_x));
					dy = longint'(map_y[i]) - longint'($signed(item.pos_y));
					d = dx * dx + dy * dy;
					if (d < best) begin
						best = d;
						r.status = STAT_OK;
						r.label_out = map_label[i];
					end
				end
				if (r.status == STAT_OK)
					n_found++;
				else
					n_missed++;
			end
			default: ;
		endcase
		r.entry_count = COUNT_W'(map_count);
		return r;
	endfunction

	task automatic send_item(input req_t item);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		expected_rsp.push_back(lookup_nearest(item));
		if (item.cmd == CMD_UNUSED)
			n_unused++;
		else
			n_sent++;
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		n_checked++;
		if (expected_rsp.size() == 0) begin
			$error("result with no command pending: status %0d label_out %h entry_count %0d",
				got.status, got.label_out, got.entry_count);
			fail_count++;
		end else begin
			want = expected_rsp.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fail_count++;
			end
			if (got.label_out !== want.label_out) begin
				$error("label_out: expected %h, got %h", want.label_out, got.label_out);
				fail_count++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
				fail_count++;
			end
		end
	endtask

	// result side: check each accepted item, then stall for a wait drawn by draw_wait
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			check_result(rsp);
			rx_wait = draw_wait();
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		rsp_stall <= (rx_wait > 0);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_rsp.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(make_req(CMD_QUERY, 0, 0, 16'h1234));  // empty table straight out of reset
		send_item(make_req(CMD_CLEAR, 16'sh7FFF, 16'sh8000, 16'hFFFF));
		send_item(make_req(CMD_QUERY, 0, 0, 16'h0000));
		send_item(make_req(CMD_APPEND, 16'sh8000, 16'sh8000, 16'hFFFF));
		send_item(make_req(CMD_APPEND, 16'sh7FFF, 16'sh7FFF, 16'h0001));
		send_item(make_req(CMD_QUERY, 16'sh7FFF, 16'sh7FFF, 16'hAAAA));
		send_item(make_req(CMD_QUERY, 16'sh8000, 16'sh8000, 16'h5555));
		send_item(make_req(CMD_QUERY, 0, 0, 16'hFFFF));
		send_item(make_req(CMD_UNUSED, 16'sh1357, -16'sh2468, 16'hBEEF));
		// exactly 1000 away is out of range
		send_item(make_req(CMD_APPEND, 1000, 0, 16'h0100));
		send_item(make_req(CMD_QUERY, 0, 0, 16'h0000));
		send_item(make_req(CMD_APPEND, 600, 800, 16'h0200));
		send_item(make_req(CMD_QUERY, 0, 0, 16'h0000));
		send_item(make_req(CMD_APPEND, 999, 0, 16'h0300));
		send_item(make_req(CMD_QUERY, 0, 0, 16'h0000));
		// equal distance, later entry must lose
		send_item(make_req(CMD_APPEND, 0, -999, 16'h0400));
		send_item(make_req(CMD_QUERY, 0, 0, 16'h0000));
		send_item(make_req(CMD_APPEND, -1, -1, 16'h0500));
		send_item(make_req(CMD_QUERY, 0, 0, 16'h0000));
		send_item(make_req(CMD_QUERY, 16'sh8000, 16'sh7FFF, 16'h0000));
		send_item(make_req(CMD_CLEAR, 0, 0, 16'h0000));
		send_item(make_req(CMD_QUERY, -1, -1, 16'h0000));
		send_item(make_req(CMD_APPEND, 5, 5, 16'h0600));
		send_item(make_req(CMD_QUERY, 5, 5, 16'h0000));
	endtask

	task automatic test_full_table();
		int i;
		send_item(make_req(CMD_CLEAR, 0, 0, 16'h0000));
		for (i = 0; i < DEPTH; i++)
			send_item(make_req(CMD_APPEND, COORD_W'(i * 40), 0, LABEL_W'(i + 1)));
		send_item(make_req(CMD_APPEND, 16'sh8000, 16'sh7FFF, 16'hDEAD));
		send_item(make_req(CMD_APPEND, 0, 0, 16'hBEEF));
		send_item(make_req(CMD_QUERY, COORD_W'((DEPTH - 1) * 40), 3, 16'h0000));
		send_item(make_req(CMD_QUERY, 0, 0, 16'h0000));
		send_item(make_req(CMD_QUERY, 1260, -7, 16'h0000));
		send_item(make_req(CMD_UNUSED, 0, 0, 16'h0000));
		send_item(make_req(CMD_QUERY, 16'sh8000, 16'sh8000, 16'h0000));
		wait_for_results();
		send_item(make_req(CMD_CLEAR, 0, 0, 16'h0000));
		send_item(make_req(CMD_QUERY, 0, 0, 16'h0000));
	endtask

	// mostly clustered point sets with nearby queries, some raw noise
	task automatic test_random();
		int base;
		int kind;
		int points;
		int queries;
		int k;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		base = n_sent;
		while (n_sent - base < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				if ($urandom_range(0, 4) != 0)
					send_item(make_req(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom)));
				cx = 16'($urandom);
				cy = 16'($urandom);
				px = cx;
				py = cy;
				points = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70)
					: $urandom_range(1, 16);
				for (k = 0; k < points; k++) begin
					// sometimes reuse the last spot to force ties
					if (k == 0 || $urandom_range(0, 5) != 0) begin
						px = cx + near_offset();
						py = cy + near_offset();
					end
					send_item(make_req(CMD_APPEND, px, py, 16'($urandom)));
					if ($urandom_range(0, 3) == 0)
						send_item(make_req(CMD_QUERY, cx + near_offset(), cy + near_offset(),
							16'($urandom)));
				end
				queries = $urandom_range(1, 8);
				for (k = 0; k < queries; k++) begin
					if ($urandom_range(0, 4) == 0)
						send_item(make_req(CMD_QUERY, px, py, 16'($urandom)));
					else
						send_item(make_req(CMD_QUERY, cx + near_offset(), cy + near_offset(),
							16'($urandom)));
				end
			end else begin
				points = $urandom_range(1, 10);
				for (k = 0; k < points; k++)
					send_item(make_req(2'($urandom_range(CMD_CLEAR, CMD_UNUSED)),
						16'($urandom), 16'($urandom), 16'($urandom)));
			end
			if ($urandom_range(0, 5) == 0)
				wait_for_results();
		end
		no_idle = 1'b0;
		wait_for_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_for_results();
		test_full_table();
		test_random();
		repeat (DEPTH + 20) @(posedge clk);
		$display("Sent %0d commands and %0d with the unused code; %0d results checked.",
			n_sent, n_unused, n_checked);
		$display("Queries: %0d hits, %0d with nothing in range; %0d appends hit a full table.",
			n_found, n_missed, n_dropped);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
